// ===== sv/gbs_pkg.sv =====
package gbs_pkg;

    localparam int GBS_MAX_BOXES = 64;

    // one pixel in Q12.4
    localparam logic signed [17:0] GBS_ONE_PIXEL = 18'sd16;

    localparam logic [15:0] GBS_IOU_THR_RESET = 16'd13107;

    // register byte addresses
    localparam logic [2:0] GBS_ADDR_IOU_THR = 3'd0;

    // one stored box; last field (score) in the lowest bits, as on the stream
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
        logic [15:0] score;
    } t_box;

endpackage

// ===== sv/gbs_store.sv =====
module gbs_store
    import gbs_pkg::*;
#(
    parameter int DEPTH = GBS_MAX_BOXES,
    parameter int AW    = $clog2(GBS_MAX_BOXES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_box          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_box          o_rdata
);

    t_box r_mem [DEPTH];
    t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/greedy_box_suppression.sv =====
// Greedy box suppression. Boxes stream in on s_axis; each is insertion-sorted
// by descending score (ties keep arrival order) into a dual-port box store,
// shifting each stored box of lower score down one slot; a dropped box is
// not stored. The transfer with tlast starts the sweep: every kept box goes
// out on m_axis and suppresses later boxes whose IoU exceeds iou_threshold.
// Each live pair is checked by one shared 18x18 multiplier; a pair whose
// boxes do not overlap is passed over without a multiply.
// The input is not ready during an insertion or the sweep. Boxes past
// MAX_BOXES are dropped and tuser is set on every result of that set.
module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_BOXES = GBS_MAX_BOXES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // score, left, top, right, bottom, tag
    input  logic [95:0] s_axis_tdata,
    // final_box
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kept_score, kept_left, kept_top, kept_right, kept_bottom, kept_tag
    output logic [95:0] m_axis_tdata,
    // last_kept
    output logic        m_axis_tlast,
    // overflowed
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INS_CHK  = 4'd1;
    localparam logic [3:0] ST_INS_RD   = 4'd2;
    localparam logic [3:0] ST_SW_NEXT  = 4'd3;
    localparam logic [3:0] ST_SW_REF   = 4'd4;
    localparam logic [3:0] ST_SW_AREA  = 4'd5;
    localparam logic [3:0] ST_PJ_NEXT  = 4'd6;
    localparam logic [3:0] ST_PJ_GEO   = 4'd7;
    localparam logic [3:0] ST_PJ_INTER = 4'd8;
    localparam logic [3:0] ST_PJ_AREAB = 4'd9;
    localparam logic [3:0] ST_PJ_UNI   = 4'd10;
    localparam logic [3:0] ST_PJ_LO    = 4'd11;
    localparam logic [3:0] ST_PJ_HI    = 4'd12;
    localparam logic [3:0] ST_PJ_CMP   = 4'd13;
    localparam logic [3:0] ST_EMIT     = 4'd14;

    // control state
    logic [3:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [MAX_BOXES-1:0] r_mask, n_mask;
    logic [15:0]          r_thr, n_thr;
    logic [CNT_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_j, n_j;
    logic                 r_final, n_final;

    // datapath
    t_box                r_new;
    t_box                r_ref;
    logic                r_olast;
    logic signed [17:0]  r_aw, r_ah, r_w, r_h, r_bw, r_bh;
    logic signed [35:0]  r_area_a, r_inter, r_area_b;
    logic signed [37:0]  r_uni;
    logic [50:0]         r_acc;
    logic [34:0]         r_phi;

    // store ports
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    t_box             st_wdata;
    logic [IDX_W-1:0] st_raddr;
    t_box             st_rdata;

    // shared multiplier
    logic signed [17:0] m_a, m_b;
    logic signed [35:0] m_p;

    // pair geometry from the reference box and the box just read
    logic [15:0]        g_x1, g_y1, g_x2, g_y2;
    logic signed [17:0] g_w, g_h, g_bw, g_bh;
    logic signed [17:0] ref_w, ref_h;
    logic               later_live;
    logic               in_fire, cfg_wr;

    gbs_store #(
        .DEPTH (MAX_BOXES),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = r_ref;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ovf;
    assign pready        = 1'b1;
    assign prdata        = (paddr == GBS_ADDR_IOU_THR) ? {16'd0, r_thr} : 32'd0;

    assign g_x1 = (r_ref.left > st_rdata.left) ? r_ref.left : st_rdata.left;
    assign g_y1 = (r_ref.top > st_rdata.top) ? r_ref.top : st_rdata.top;
    assign g_x2 = (r_ref.right < st_rdata.right) ? r_ref.right : st_rdata.right;
    assign g_y2 = (r_ref.bottom < st_rdata.bottom) ? r_ref.bottom : st_rdata.bottom;
    assign g_w  = $signed({2'b00, g_x2}) - $signed({2'b00, g_x1}) + GBS_ONE_PIXEL;
    assign g_h  = $signed({2'b00, g_y2}) - $signed({2'b00, g_y1}) + GBS_ONE_PIXEL;
    assign g_bw = $signed({2'b00, st_rdata.right}) - $signed({2'b00, st_rdata.left})
                  + GBS_ONE_PIXEL;
    assign g_bh = $signed({2'b00, st_rdata.bottom}) - $signed({2'b00, st_rdata.top})
                  + GBS_ONE_PIXEL;
    assign ref_w = $signed({2'b00, st_rdata.right}) - $signed({2'b00, st_rdata.left})
                   + GBS_ONE_PIXEL;
    assign ref_h = $signed({2'b00, st_rdata.bottom}) - $signed({2'b00, st_rdata.top})
                   + GBS_ONE_PIXEL;

    // any unsuppressed box after the current reference
    always_comb begin
        later_live = 1'b0;
        for (int k = 0; k < MAX_BOXES; k++) begin
            if ((CNT_W'(k) > r_i) && (CNT_W'(k) < r_count) && !r_mask[k]) begin
                later_live = 1'b1;
            end
        end
    end

    always_comb begin
        case (r_state)
            ST_SW_AREA: begin
                m_a = r_aw;
                m_b = r_ah;
            end
            ST_PJ_INTER: begin
                m_a = r_w;
                m_b = r_h;
            end
            ST_PJ_AREAB: begin
                m_a = r_bw;
                m_b = r_bh;
            end
            ST_PJ_LO: begin
                m_a = $signed({2'b00, r_thr});
                m_b = $signed({1'b0, r_uni[16:0]});
            end
            ST_PJ_HI: begin
                m_a = $signed({2'b00, r_thr});
                m_b = $signed({1'b0, r_uni[33:17]});
            end
            default: begin
                m_a = 18'sd0;
                m_b = 18'sd0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_mask   = r_mask;
        n_thr    = r_thr;
        n_pos    = r_pos;
        n_i      = r_i;
        n_j      = r_j;
        n_final  = r_final;
        st_we    = 1'b0;
        st_waddr = r_pos[IDX_W-1:0];
        st_wdata = r_new;
        st_raddr = r_i[IDX_W-1:0];

        if (cfg_wr && (paddr == GBS_ADDR_IOU_THR)) begin
            n_thr = pwdata[15:0];
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_final = s_axis_tlast;
                    n_pos   = r_count;
                    n_i     = '0;
                    if (r_count == CNT_MAX) begin
                        // drop the box, keep the set
                        n_ovf   = 1'b1;
                        n_state = s_axis_tlast ? ST_SW_NEXT : ST_IDLE;
                    end else begin
                        n_state = ST_INS_CHK;
                    end
                end
            end
            ST_INS_CHK: begin
                st_raddr = IDX_W'(r_pos - CNT_ONE);
                if (r_pos == '0) begin
                    st_we   = 1'b1;
                    n_count = r_count + CNT_ONE;
                    n_state = r_final ? ST_SW_NEXT : ST_IDLE;
                end else begin
                    n_state = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                st_we = 1'b1;
                if (st_rdata.score < r_new.score) begin
                    // shift the lower-scored box down one slot
                    st_wdata = st_rdata;
                    n_pos    = r_pos - CNT_ONE;
                    n_state  = ST_INS_CHK;
                end else begin
                    n_count = r_count + CNT_ONE;
                    n_state = r_final ? ST_SW_NEXT : ST_IDLE;
                end
            end
            ST_SW_NEXT: begin
                st_raddr = r_i[IDX_W-1:0];
                if (r_i == r_count) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_mask  = '0;
                    n_state = ST_IDLE;
                end else if (r_mask[r_i[IDX_W-1:0]]) begin
                    n_i = r_i + CNT_ONE;
                end else begin
                    n_mask[r_i[IDX_W-1:0]] = 1'b1;
                    n_state = ST_SW_REF;
                end
            end
            ST_SW_REF: begin
                n_state = ST_SW_AREA;
            end
            ST_SW_AREA: begin
                n_j     = r_i + CNT_ONE;
                n_state = ST_PJ_NEXT;
            end
            ST_PJ_NEXT: begin
                st_raddr = r_j[IDX_W-1:0];
                if (r_j == r_count) begin
                    n_state = ST_EMIT;
                end else if (r_mask[r_j[IDX_W-1:0]]) begin
                    n_j = r_j + CNT_ONE;
                end else begin
                    n_state = ST_PJ_GEO;
                end
            end
            ST_PJ_GEO: begin
                if ((g_w <= 18'sd0) || (g_h <= 18'sd0)) begin
                    n_j     = r_j + CNT_ONE;
                    n_state = ST_PJ_NEXT;
                end else begin
                    n_state = ST_PJ_INTER;
                end
            end
            ST_PJ_INTER: begin
                n_state = ST_PJ_AREAB;
            end
            ST_PJ_AREAB: begin
                n_state = ST_PJ_UNI;
            end
            ST_PJ_UNI: begin
                n_state = ST_PJ_LO;
            end
            ST_PJ_LO: begin
                // zero union suppresses, negative union keeps
                if (r_uni == 38'sd0) begin
                    n_mask[r_j[IDX_W-1:0]] = 1'b1;
                    n_j     = r_j + CNT_ONE;
                    n_state = ST_PJ_NEXT;
                end else if (r_uni < 38'sd0) begin
                    n_j     = r_j + CNT_ONE;
                    n_state = ST_PJ_NEXT;
                end else begin
                    n_state = ST_PJ_HI;
                end
            end
            ST_PJ_HI: begin
                n_state = ST_PJ_CMP;
            end
            ST_PJ_CMP: begin
                if ({3'd0, r_inter[32:0], 16'd0} >
                    ({1'b0, r_acc} + {r_phi, 17'd0})) begin
                    n_mask[r_j[IDX_W-1:0]] = 1'b1;
                end
                n_j     = r_j + CNT_ONE;
                n_state = ST_PJ_NEXT;
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    n_i     = r_i + CNT_ONE;
                    n_state = ST_SW_NEXT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_mask  <= '0;
            r_thr   <= GBS_IOU_THR_RESET;
            r_pos   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_mask  <= n_mask;
            r_thr   <= n_thr;
            r_pos   <= n_pos;
            r_i     <= n_i;
            r_j     <= n_j;
            r_final <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_new <= t_box'(s_axis_tdata);
        end
        case (r_state)
            ST_SW_REF: begin
                r_ref <= st_rdata;
                r_aw  <= ref_w;
                r_ah  <= ref_h;
            end
            ST_SW_AREA: begin
                r_area_a <= m_p;
            end
            ST_PJ_NEXT: begin
                r_olast <= !later_live;
            end
            ST_PJ_GEO: begin
                r_w  <= g_w;
                r_h  <= g_h;
                r_bw <= g_bw;
                r_bh <= g_bh;
            end
            ST_PJ_INTER: begin
                r_inter <= m_p;
            end
            ST_PJ_AREAB: begin
                r_area_b <= m_p;
            end
            ST_PJ_UNI: begin
                r_uni <= 38'(r_area_a) + 38'(r_area_b) - 38'(r_inter);
            end
            ST_PJ_LO: begin
                r_acc <= {16'd0, m_p[34:0]};
            end
            ST_PJ_HI: begin
                r_phi <= m_p[34:0];
            end
            default: begin
                r_olast <= r_olast;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("box count above capacity");

    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_state == ST_EMIT) && !s_axis_tready)
        else $error("result shown outside the emit step");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SW_NEXT && r_i == r_count) |=>
            (r_count == '0) && !r_ovf && (r_mask == '0))
        else $error("set not cleared after sweep");

    a_ref_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PJ_NEXT) |-> r_mask[r_i[IDX_W-1:0]] && (r_j > r_i))
        else $error("reference box not marked during pair scan");

endmodule

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
    import gbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        t_box b;
        bit   last;
        bit   ovf;
    } t_kept;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    greedy_box_suppression u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    t_box        held[GBS_MAX_BOXES];
    int          held_n = 0;
    bit          held_ovf = 1'b0;
    logic [15:0] iou_thr = GBS_IOU_THR_RESET;
    t_kept       kept_q[$];

    int fails = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    function automatic bit too_much_overlap(t_box a, t_box b);
        longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, w, h, area_a, area_b, inter, uni;
        ax1 = a.left;  ay1 = a.top;  ax2 = a.right;  ay2 = a.bottom;
        bx1 = b.left;  by1 = b.top;  bx2 = b.right;  by2 = b.bottom;
        w = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1) + 16;
        h = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1) + 16;
        if (w <= 0 || h <= 0) return 1'b0;
        area_a = (ax2 - ax1 + 16) * (ay2 - ay1 + 16);
        area_b = (bx2 - bx1 + 16) * (by2 - by1 + 16);
        inter = w * h;
        uni = area_a + area_b - inter;
        if (uni == 0) return 1'b1;
        if (uni < 0) return 1'b0;
        return inter * 65536 > longint'(iou_thr) * uni;
    endfunction

    // insertion sort, then the greedy sweep when the set closes
    function automatic void absorb_box(t_box b, bit fin);
        int pos;
        bit gone[GBS_MAX_BOXES];
        t_kept k;
        if (held_n >= GBS_MAX_BOXES) begin
            held_ovf = 1'b1;
        end else begin
            pos = held_n;
            while (pos > 0 && held[pos-1].score < b.score) begin
                held[pos] = held[pos-1];
                pos--;
            end
            held[pos] = b;
            held_n++;
        end
        if (!fin) return;
        foreach (gone[i]) gone[i] = 1'b0;
        for (int i = 0; i < held_n; i++) begin
            if (gone[i]) continue;
            k.b = held[i];
            k.last = 1'b0;
            k.ovf = held_ovf;
            kept_q.insert(kept_q.size(), k);
            for (int j = i + 1; j < held_n; j++)
                if (!gone[j] && too_much_overlap(held[i], held[j])) gone[j] = 1'b1;
        end
        kept_q[kept_q.size()-1].last = 1'b1;
        held_n = 0;
        held_ovf = 1'b0;
    endfunction

    task automatic send_box(input t_box b, input bit fin);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        absorb_box(b, fin);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // wait for the last result and for the sweep to finish
    task automatic drain();
        stop_sending();
        while (kept_q.size() != 0 || !s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_iou_thr(input logic [15:0] value);
        drain();
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= GBS_ADDR_IOU_THR;
        pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        iou_thr = value;
    endtask

    function automatic t_box make_box(input logic [15:0] score, input logic [15:0] l,
                                      input logic [15:0] t, input logic [15:0] r,
                                      input logic [15:0] btm, input logic [15:0] tag);
        t_box b;
        b.score = score; b.left = l; b.top = t; b.right = r; b.bottom = btm; b.tag = tag;
        return b;
    endfunction

    // mostly clustered boxes so that overlaps happen; some fully random
    function automatic t_box random_box();
        t_box b;
        logic [15:0] w, h;
        if ($urandom_range(7) == 0) begin
            b = {$urandom, $urandom, $urandom};
        end else begin
            b.left = 16'($urandom_range(0, 1200));
            b.top = 16'($urandom_range(0, 1200));
            w = 16'($urandom_range(0, 800));
            h = 16'($urandom_range(0, 800));
            b.right = b.left + w;
            b.bottom = b.top + h;
            b.score = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            b.tag = 16'($urandom);
        end
        return b;
    endfunction

    task automatic send_random_set(input int n);
        for (int i = 0; i < n; i++) send_box(random_box(), i == n - 1);
    endtask

    function automatic int random_set_size();
        return ($urandom_range(19) == 0)
               ? int'($urandom_range(GBS_MAX_BOXES, GBS_MAX_BOXES + 2))
               : int'($urandom_range(1, 10));
    endfunction

    task automatic test_directed();
        // ties, extremes, an inverted box, a disjoint pair and an identical pair
        send_box(make_box(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000), 0);
        send_box(make_box(16'h0000, 16'h0010, 16'h0010, 16'h0100, 16'h0100, 16'hFFFF), 0);
        send_box(make_box(16'hFFFF, 16'h0000, 16'h0000, 16'h00F0, 16'h00F0, 16'h1234), 0);
        send_box(make_box(16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hAAAA), 0);
        send_box(make_box(16'h7000, 16'h5000, 16'h5000, 16'h5100, 16'h5100, 16'h5555), 0);
        send_box(make_box(16'h7000, 16'h5000, 16'h5000, 16'h5100, 16'h5100, 16'h5556), 0);
        send_box(make_box(16'h6000, 16'h9000, 16'h9000, 16'h9010, 16'h9010, 16'h0F0F), 1);
        // a set of one box
        send_box(make_box(16'h1234, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'hBEEF), 1);
    endtask

    task automatic test_thresholds();
        logic [15:0] thr_list[3] = '{16'd0, 16'hFFFF, 16'd40000};
        foreach (thr_list[k]) begin
            write_iou_thr(thr_list[k]);
            send_box(make_box(16'h9000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0001), 0);
            send_box(make_box(16'h8000, 16'h00F0, 16'h00F0, 16'h0200, 16'h0200, 16'h0002), 0);
            send_box(make_box(16'h7000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0003), 0);
            send_box(make_box(16'h6000, 16'h0010, 16'h0000, 16'h0110, 16'h0100, 16'h0004), 1);
        end
        write_iou_thr(GBS_IOU_THR_RESET);
    endtask

    task automatic test_overflow();
        // full store; in the first two sets the closing box is itself dropped
        send_random_set(GBS_MAX_BOXES + 1);
        send_random_set(GBS_MAX_BOXES + 3);
        send_random_set(GBS_MAX_BOXES);
    endtask

    task automatic test_random();
        int idle_pct[4] = '{0, 72, 0, 24};
        int stall_pct[4] = '{0, 0, 72, 24};
        logic [15:0] thr_list[4] = '{16'd13107, 16'd0, 16'hFFFF, 16'd30000};
        int sent;
        foreach (idle_pct[p]) begin
            write_iou_thr(thr_list[p]);
            send_idle = idle_pct[p];
            recv_stall = stall_pct[p];
            sent = 0;
            while (sent < 50) begin
                int n;
                n = random_set_size();
                send_random_set(n);
                sent += n;
            end
        end
        send_idle = 0;
        recv_stall = 0;
    endtask

    task automatic test_backpressure();
        drain();
        hold_cycles = 600;
        send_random_set(8);
        send_random_set(6);
        send_random_set(5);
        drain();
        send_random_set(4);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_thresholds();
        test_overflow();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_kept k;
        t_box got;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (kept_q.size() == 0) begin
                fails++;
                $display("%0t unexpected result: expected none actual %h", $realtime,
                         m_axis_tdata);
            end else begin
                k = kept_q.pop_front();
                check_field("kept_score", k.b.score, got.score);
                check_field("kept_left", k.b.left, got.left);
                check_field("kept_top", k.b.top, got.top);
                check_field("kept_right", k.b.right, got.right);
                check_field("kept_bottom", k.b.bottom, got.bottom);
                check_field("kept_tag", k.b.tag, got.tag);
                check_field("last_kept", 16'(k.last), 16'(m_axis_tlast));
                check_field("overflowed", 16'(k.ovf), 16'(m_axis_tuser));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable) || !i_rst_n || hold_cycles > 0) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/gbs_pkg.sv
sv/gbs_store.sv
sv/greedy_box_suppression.sv
tb/sv/tb.sv
